// ----- rtl/wiep_pkg.sv -----
package wiep_pkg;

    // parse phases
    localparam logic [4:0] PH_HDR_OK      = 5'd0;
    localparam logic [4:0] PH_HDR_BAD     = 5'd1;
    localparam logic [4:0] PH_SEC_ID      = 5'd2;
    localparam logic [4:0] PH_SZ_IMP      = 5'd3;
    localparam logic [4:0] PH_SZ_EXP      = 5'd4;
    localparam logic [4:0] PH_SZ_SKIP     = 5'd5;
    localparam logic [4:0] PH_SKIP        = 5'd6;
    localparam logic [4:0] PH_IMP_COUNT   = 5'd7;
    localparam logic [4:0] PH_IMP_MODLEN  = 5'd8;
    localparam logic [4:0] PH_IMP_MODCHR  = 5'd9;
    localparam logic [4:0] PH_IMP_NAMLEN  = 5'd10;
    localparam logic [4:0] PH_IMP_NAMCHR  = 5'd11;
    localparam logic [4:0] PH_IMP_KIND    = 5'd12;
    localparam logic [4:0] PH_IMP_TYPEIDX = 5'd13;
    localparam logic [4:0] PH_IMP_ELEM    = 5'd14;
    localparam logic [4:0] PH_IMP_FLAGS   = 5'd15;
    localparam logic [4:0] PH_IMP_INIT    = 5'd16;
    localparam logic [4:0] PH_IMP_MAX     = 5'd17;
    localparam logic [4:0] PH_IMP_VALTYPE = 5'd18;
    localparam logic [4:0] PH_IMP_MUT     = 5'd19;
    localparam logic [4:0] PH_EXP_COUNT   = 5'd20;
    localparam logic [4:0] PH_EXP_NAMLEN  = 5'd21;
    localparam logic [4:0] PH_EXP_NAMCHR  = 5'd22;
    localparam logic [4:0] PH_EXP_KIND    = 5'd23;
    localparam logic [4:0] PH_EXP_INDEX   = 5'd24;
    localparam logic [4:0] PH_DONE        = 5'd25;

    // record types
    localparam logic [3:0] REC_BAD_HDR   = 4'd0;
    localparam logic [3:0] REC_IMP_CNT   = 4'd1;
    localparam logic [3:0] REC_EXP_CNT   = 4'd2;
    localparam logic [3:0] REC_MOD_LEN   = 4'd3;
    localparam logic [3:0] REC_MOD_CHR   = 4'd4;
    localparam logic [3:0] REC_NAM_LEN   = 4'd5;
    localparam logic [3:0] REC_NAM_CHR   = 4'd6;
    localparam logic [3:0] REC_IMP_KIND  = 4'd7;
    localparam logic [3:0] REC_TYPE_IDX  = 4'd8;
    localparam logic [3:0] REC_ELEM      = 4'd9;
    localparam logic [3:0] REC_INIT      = 4'd10;
    localparam logic [3:0] REC_MAX       = 4'd11;
    localparam logic [3:0] REC_VALTYPE   = 4'd12;
    localparam logic [3:0] REC_MUT       = 4'd13;
    localparam logic [3:0] REC_EXP_KIND  = 4'd14;
    localparam logic [3:0] REC_EXP_IDX   = 4'd15;

    localparam int unsigned REC_W = 38;

    typedef struct packed {
        logic [3:0]  rtype;
        logic [31:0] value;
        logic        last;
        logic        all;
    } rec_t;

    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] r;
        begin
            unique case (pos)
                3'd1:    r = 8'h61;
                3'd2:    r = 8'h73;
                3'd3:    r = 8'h6D;
                3'd4:    r = 8'h01;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/wiep_front.sv -----
module wiep_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               in_sof,
    output logic               rec_valid,
    output wiep_pkg::rec_t     rec
);

    logic [4:0]  phase_reg,   phase_next;
    logic [2:0]  hpos_reg,    hpos_next;
    logic [31:0] acc_reg,     acc_next;
    logic [2:0]  lidx_reg,    lidx_next;
    logic [31:0] ent_reg,     ent_next;
    logic [31:0] bytes_reg,   bytes_next;
    logic        maxp_reg,    maxp_next;
    logic        imps_reg,    imps_next;
    logic        exps_reg,    exps_next;

    // effective state after optional restart
    logic [4:0]  ph;
    logic [2:0]  hp;
    logic [31:0] ac;
    logic [2:0]  li;
    logic        im, ex;
    logic [31:0] acc_or, leb_val, ent_dec, bytes_dec;
    logic        leb_done;

    always_comb
    begin
        ph = in_sof ? wiep_pkg::PH_HDR_OK : phase_reg;
        hp = in_sof ? 3'd0 : hpos_reg;
        ac = in_sof ? 32'd0 : acc_reg;
        li = in_sof ? 3'd0 : lidx_reg;
        im = in_sof ? 1'b0 : imps_reg;
        ex = in_sof ? 1'b0 : exps_reg;
        // accumulate one LEB128 group
        unique case (li)
            3'd0:    acc_or = ac | {25'd0, in_byte[6:0]};
            3'd1:    acc_or = ac | {18'd0, in_byte[6:0], 7'd0};
            3'd2:    acc_or = ac | {11'd0, in_byte[6:0], 14'd0};
            3'd3:    acc_or = ac | {4'd0, in_byte[6:0], 21'd0};
            3'd4:    acc_or = ac | {in_byte[3:0], 28'd0};
            default: acc_or = ac;
        endcase
        leb_val   = acc_or;
        leb_done  = !in_byte[7];
        ent_dec   = ent_reg - 32'd1;
        bytes_dec = bytes_reg - 32'd1;
    end

    always_comb
    begin
        logic is_leb;
        logic imp;
        logic fin;
        is_leb = 1'b0;
        imp = 1'b0;
        fin = 1'b0;
        phase_next = ph;
        hpos_next  = hp;
        acc_next   = ac;
        lidx_next  = li;
        ent_next   = ent_reg;
        bytes_next = bytes_reg;
        maxp_next  = maxp_reg;
        imps_next  = im;
        exps_next  = ex;
        rec_valid  = 1'b0;
        rec        = '0;
        unique case (ph)
            wiep_pkg::PH_SZ_IMP, wiep_pkg::PH_SZ_EXP, wiep_pkg::PH_SZ_SKIP,
            wiep_pkg::PH_IMP_COUNT, wiep_pkg::PH_EXP_COUNT, wiep_pkg::PH_IMP_MODLEN,
            wiep_pkg::PH_IMP_NAMLEN, wiep_pkg::PH_EXP_NAMLEN, wiep_pkg::PH_IMP_TYPEIDX,
            wiep_pkg::PH_IMP_INIT, wiep_pkg::PH_IMP_MAX, wiep_pkg::PH_EXP_INDEX:
                is_leb = 1'b1;
            default: is_leb = 1'b0;
        endcase
        // advance the varint decoder
        if (is_leb)
        begin
            if (leb_done)
            begin
                acc_next  = 32'd0;
                lidx_next = 3'd0;
            end
            else
            begin
                acc_next  = acc_or;
                lidx_next = (li < 3'd5) ? li + 3'd1 : li;
            end
        end
        unique case (ph)
            wiep_pkg::PH_HDR_OK, wiep_pkg::PH_HDR_BAD:
            begin
                if (in_byte != wiep_pkg::hdr_byte(hp))
                    phase_next = wiep_pkg::PH_HDR_BAD;
                if (hp == 3'd7)
                begin
                    hpos_next = 3'd0;
                    if (phase_next == wiep_pkg::PH_HDR_BAD)
                    begin
                        phase_next = wiep_pkg::PH_DONE;
                        rec_valid = 1'b1;
                        rec = '{wiep_pkg::REC_BAD_HDR, 32'd0, 1'b1, 1'b0};
                    end
                    else
                        phase_next = wiep_pkg::PH_SEC_ID;
                end
                else
                    hpos_next = hp + 3'd1;
            end
            wiep_pkg::PH_SEC_ID:
                phase_next = (in_byte == 8'd2) ? wiep_pkg::PH_SZ_IMP :
                             (in_byte == 8'd7) ? wiep_pkg::PH_SZ_EXP : wiep_pkg::PH_SZ_SKIP;
            wiep_pkg::PH_SZ_IMP:
                if (leb_done) phase_next = wiep_pkg::PH_IMP_COUNT;
            wiep_pkg::PH_SZ_EXP:
                if (leb_done) phase_next = wiep_pkg::PH_EXP_COUNT;
            wiep_pkg::PH_SZ_SKIP:
                if (leb_done)
                begin
                    bytes_next = leb_val;
                    phase_next = (leb_val != 32'd0) ? wiep_pkg::PH_SKIP : wiep_pkg::PH_SEC_ID;
                end
            wiep_pkg::PH_SKIP:
            begin
                bytes_next = bytes_dec;
                if (bytes_dec == 32'd0) phase_next = wiep_pkg::PH_SEC_ID;
            end
            wiep_pkg::PH_IMP_COUNT, wiep_pkg::PH_EXP_COUNT:
                if (leb_done)
                begin
                    imp = (ph == wiep_pkg::PH_IMP_COUNT);
                    ent_next = leb_val;
                    rec_valid = 1'b1;
                    rec.rtype = imp ? wiep_pkg::REC_IMP_CNT : wiep_pkg::REC_EXP_CNT;
                    rec.value = leb_val;
                    if (leb_val == 32'd0)
                    begin
                        fin = 1'b1;
                        rec.last = 1'b1;
                    end
                    else
                        phase_next = imp ? wiep_pkg::PH_IMP_MODLEN : wiep_pkg::PH_EXP_NAMLEN;
                end
            wiep_pkg::PH_IMP_MODLEN:
                if (leb_done)
                begin
                    bytes_next = leb_val;
                    phase_next = (leb_val != 32'd0) ? wiep_pkg::PH_IMP_MODCHR
                                                    : wiep_pkg::PH_IMP_NAMLEN;
                    rec_valid = 1'b1;
                    rec = '{wiep_pkg::REC_MOD_LEN, leb_val, 1'b0, 1'b0};
                end
            wiep_pkg::PH_IMP_MODCHR:
            begin
                bytes_next = bytes_dec;
                if (bytes_dec == 32'd0) phase_next = wiep_pkg::PH_IMP_NAMLEN;
                rec_valid = 1'b1;
                rec = '{wiep_pkg::REC_MOD_CHR, {24'd0, in_byte}, 1'b0, 1'b0};
            end
            wiep_pkg::PH_IMP_NAMLEN, wiep_pkg::PH_EXP_NAMLEN:
                if (leb_done)
                begin
                    imp = (ph == wiep_pkg::PH_IMP_NAMLEN);
                    bytes_next = leb_val;
                    if (leb_val != 32'd0)
                        phase_next = imp ? wiep_pkg::PH_IMP_NAMCHR : wiep_pkg::PH_EXP_NAMCHR;
                    else
                        phase_next = imp ? wiep_pkg::PH_IMP_KIND : wiep_pkg::PH_EXP_KIND;
                    rec_valid = 1'b1;
                    rec = '{wiep_pkg::REC_NAM_LEN, leb_val, 1'b0, 1'b0};
                end
            wiep_pkg::PH_IMP_NAMCHR, wiep_pkg::PH_EXP_NAMCHR:
            begin
                bytes_next = bytes_dec;
                if (bytes_dec == 32'd0)
                    phase_next = (ph == wiep_pkg::PH_IMP_NAMCHR) ? wiep_pkg::PH_IMP_KIND
                                                                : wiep_pkg::PH_EXP_KIND;
                rec_valid = 1'b1;
                rec = '{wiep_pkg::REC_NAM_CHR, {24'd0, in_byte}, 1'b0, 1'b0};
            end
            wiep_pkg::PH_IMP_KIND:
            begin
                rec_valid = 1'b1;
                rec = '{wiep_pkg::REC_IMP_KIND, {24'd0, in_byte}, 1'b0, 1'b0};
                priority if (in_byte > 8'd3)
                begin
                    imp = 1'b1;
                    rec.last = 1'b1;
                end
                else if (in_byte == 8'd0) phase_next = wiep_pkg::PH_IMP_TYPEIDX;
                else if (in_byte == 8'd1) phase_next = wiep_pkg::PH_IMP_ELEM;
                else if (in_byte == 8'd2) phase_next = wiep_pkg::PH_IMP_FLAGS;
                else phase_next = wiep_pkg::PH_IMP_VALTYPE;
            end
            wiep_pkg::PH_IMP_TYPEIDX:
                if (leb_done)
                begin
                    imp = 1'b1;
                    rec_valid = 1'b1;
                    rec = '{wiep_pkg::REC_TYPE_IDX, leb_val, 1'b1, 1'b0};
                end
            wiep_pkg::PH_IMP_ELEM:
            begin
                phase_next = wiep_pkg::PH_IMP_FLAGS;
                rec_valid = 1'b1;
                rec = '{wiep_pkg::REC_ELEM, {24'd0, in_byte}, 1'b0, 1'b0};
            end
            wiep_pkg::PH_IMP_FLAGS:
            begin
                maxp_next = in_byte[0];
                phase_next = wiep_pkg::PH_IMP_INIT;
            end
            wiep_pkg::PH_IMP_INIT:
                if (leb_done)
                begin
                    rec_valid = 1'b1;
                    rec = '{wiep_pkg::REC_INIT, leb_val, !maxp_reg, 1'b0};
                    if (maxp_reg) phase_next = wiep_pkg::PH_IMP_MAX;
                    else imp = 1'b1;
                end
            wiep_pkg::PH_IMP_MAX:
                if (leb_done)
                begin
                    imp = 1'b1;
                    rec_valid = 1'b1;
                    rec = '{wiep_pkg::REC_MAX, leb_val, 1'b1, 1'b0};
                end
            wiep_pkg::PH_IMP_VALTYPE:
            begin
                phase_next = wiep_pkg::PH_IMP_MUT;
                rec_valid = 1'b1;
                rec = '{wiep_pkg::REC_VALTYPE, {24'd0, in_byte}, 1'b0, 1'b0};
            end
            wiep_pkg::PH_IMP_MUT:
            begin
                imp = 1'b1;
                rec_valid = 1'b1;
                rec = '{wiep_pkg::REC_MUT, {31'd0, (in_byte != 8'd0)}, 1'b1, 1'b0};
            end
            wiep_pkg::PH_EXP_KIND:
            begin
                phase_next = wiep_pkg::PH_EXP_INDEX;
                rec_valid = 1'b1;
                rec = '{wiep_pkg::REC_EXP_KIND, {24'd0, in_byte}, 1'b0, 1'b0};
            end
            wiep_pkg::PH_EXP_INDEX:
                if (leb_done)
                begin
                    rec_valid = 1'b1;
                    rec = '{wiep_pkg::REC_EXP_IDX, leb_val, 1'b1, 1'b0};
                end
            default:
                phase_next = wiep_pkg::PH_DONE;
        endcase
        // end an entry: import and export entry ends, flagged via rec.last; imp marks an import
        if (rec_valid && rec.last && (ph == wiep_pkg::PH_IMP_KIND ||
            ph == wiep_pkg::PH_IMP_TYPEIDX || ph == wiep_pkg::PH_IMP_INIT ||
            ph == wiep_pkg::PH_IMP_MAX || ph == wiep_pkg::PH_IMP_MUT ||
            ph == wiep_pkg::PH_EXP_INDEX))
        begin
            imp = (ph != wiep_pkg::PH_EXP_INDEX);
            ent_next = ent_dec;
            if (ent_dec == 32'd0)
                fin = 1'b1;
            else
                phase_next = imp ? wiep_pkg::PH_IMP_MODLEN : wiep_pkg::PH_EXP_NAMLEN;
        end
        // finish a section
        if (fin)
        begin
            if (imp) imps_next = 1'b1;
            else exps_next = 1'b1;
            if ((imp || im) && (!imp || ex))
            begin
                phase_next = wiep_pkg::PH_DONE;
                rec.all = 1'b1;
            end
            else
                phase_next = wiep_pkg::PH_SEC_ID;
        end
    end

    // hold parser state between transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wiep_pkg::PH_HDR_OK;
            hpos_reg  <= 3'd0;
            acc_reg   <= 32'd0;
            lidx_reg  <= 3'd0;
            ent_reg   <= 32'd0;
            bytes_reg <= 32'd0;
            maxp_reg  <= 1'b0;
            imps_reg  <= 1'b0;
            exps_reg  <= 1'b0;
        end
        else if (in_valid)
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            acc_reg   <= acc_next;
            lidx_reg  <= lidx_next;
            ent_reg   <= ent_next;
            bytes_reg <= bytes_next;
            maxp_reg  <= maxp_next;
            imps_reg  <= imps_next;
            exps_reg  <= exps_next;
        end
    end

endmodule

// ----- rtl/wiep_queue.sv -----
module wiep_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    input  wiep_pkg::rec_t wr_rec,
    output logic           not_full,
    output logic           rd_valid,
    input  logic           rd_ready,
    output wiep_pkg::rec_t rd_rec
);

    wiep_pkg::rec_t mem_reg [0:1];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;

    assign not_full = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_rec   = mem_reg[rptr_reg];
    assign push     = wr_valid && not_full;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    // store a record
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_rec;
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- rtl/wasm_import_export_parser.sv -----
// WebAssembly import/export section parser. Takes one module byte per transfer and
// emits decoded import/export records (type, value, group_last, all_found). One byte
// per cycle while the record queue has room; each record is written into the queue
// when its byte is accepted. A two-entry record queue sits between the byte decoder and
// the output, so input stalls only when the output side holds back two records.
module wasm_import_export_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] record_type, [35:4] record_value, zero fill
    output logic        m_tlast,   // group_last
    output logic        m_tuser    // [0] all_found
);

    logic           rec_valid;
    wiep_pkg::rec_t rec, out_rec;
    logic           not_full;

    wiep_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid && s_tready),
        .in_byte   (s_tdata),
        .in_sof    (s_tuser),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    wiep_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (rec_valid && s_tvalid && s_tready),
        .wr_rec   (rec),
        .not_full (not_full),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_rec   (out_rec)
    );

    assign s_tready = not_full;
    assign m_tdata  = {4'd0, out_rec.value, out_rec.rtype};
    assign m_tlast  = out_rec.last;
    assign m_tuser  = out_rec.all;

endmodule

// ----- tb/tb_wasm_import_export_parser.sv -----
module tb_wasm_import_export_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import wiep_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       sof;
        logic       chk;
        logic       has;
        logic [3:0] rtype;
        logic [31:0] value;
        logic       last;
        logic       all;
    } stim_row_t;

    typedef struct packed {
        logic [3:0]  rtype;
        logic [31:0] value;
        logic        last;
        logic        all;
    } record_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    wasm_import_export_parser dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // predictor state
    logic [4:0]  phase;
    logic [2:0]  hdr_pos;
    logic [31:0] leb_acc;
    logic [2:0]  leb_idx;
    logic [31:0] entries_left;
    logic [31:0] bytes_left;
    logic        has_max;
    logic        imp_done;
    logic        exp_done;

    record_t     expected_records[$];
    int          error_count;
    int          bytes_sent;
    logic        rx_hold;
    logic        quiet;
    logic [7:0]  stream[$];
    logic        stream_sof[$];

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void parser_reset();
        phase        = PH_HDR_OK;
        hdr_pos      = 3'd0;
        leb_acc      = 32'd0;
        leb_idx      = 3'd0;
        entries_left = 32'd0;
        bytes_left   = 32'd0;
        has_max      = 1'b0;
        imp_done     = 1'b0;
        exp_done     = 1'b0;
    endfunction

    // one LEB128 byte; returns 1 when the value is complete
    function automatic logic leb_take(input logic [7:0] b, output logic [31:0] v);
        if (leb_idx < 3'd5)
        begin
            leb_acc = leb_acc | (32'(b[6:0]) << (7 * leb_idx));
            leb_idx = leb_idx + 3'd1;
        end
        v = leb_acc;
        if (b[7])
            return 1'b0;
        leb_acc = 32'd0;
        leb_idx = 3'd0;
        return 1'b1;
    endfunction

    function automatic logic close_section(input logic is_imp);
        if (is_imp)
            imp_done = 1'b1;
        else
            exp_done = 1'b1;
        if (imp_done && exp_done)
        begin
            phase = PH_DONE;
            return 1'b1;
        end
        phase = PH_SEC_ID;
        return 1'b0;
    endfunction

    function automatic logic close_entry(input logic is_imp);
        entries_left = entries_left - 32'd1;
        if (entries_left == 32'd0)
            return close_section(is_imp);
        phase = is_imp ? PH_IMP_MODLEN : PH_EXP_NAMLEN;
        return 1'b0;
    endfunction

    // advance the decoder by one byte; returns 1 with a record when one is due
    function automatic logic decode_byte(input logic [7:0] b, input logic sof,
                                         output record_t r);
        logic [31:0] v;
        logic        imp;
        r = '0;
        if (sof)
            parser_reset();
        case (phase)
            PH_HDR_OK, PH_HDR_BAD:
            begin
                if (b != hdr_byte(hdr_pos))
                    phase = PH_HDR_BAD;
                if (hdr_pos == 3'd7)
                begin
                    hdr_pos = 3'd0;
                    if (phase == PH_HDR_BAD)
                    begin
                        phase = PH_DONE;
                        r = '{REC_BAD_HDR, 32'd0, 1'b1, 1'b0};
                        return 1'b1;
                    end
                    phase = PH_SEC_ID;
                    return 1'b0;
                end
                hdr_pos = hdr_pos + 3'd1;
                return 1'b0;
            end
            PH_SEC_ID:
            begin
                phase = (b == 8'd2) ? PH_SZ_IMP : (b == 8'd7) ? PH_SZ_EXP : PH_SZ_SKIP;
                return 1'b0;
            end
            PH_SZ_IMP:
            begin
                if (leb_take(b, v))
                    phase = PH_IMP_COUNT;
                return 1'b0;
            end
            PH_SZ_EXP:
            begin
                if (leb_take(b, v))
                    phase = PH_EXP_COUNT;
                return 1'b0;
            end
            PH_SZ_SKIP:
            begin
                if (leb_take(b, v))
                begin
                    bytes_left = v;
                    phase = (v != 32'd0) ? PH_SKIP : PH_SEC_ID;
                end
                return 1'b0;
            end
            PH_SKIP:
            begin
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0)
                    phase = PH_SEC_ID;
                return 1'b0;
            end
            PH_IMP_COUNT, PH_EXP_COUNT:
            begin
                imp = (phase == PH_IMP_COUNT);
                if (!leb_take(b, v))
                    return 1'b0;
                entries_left = v;
                if (v == 32'd0)
                begin
                    r = '{imp ? REC_IMP_CNT : REC_EXP_CNT, 32'd0, 1'b1, 1'b0};
                    r.all = close_section(imp);
                    return 1'b1;
                end
                phase = imp ? PH_IMP_MODLEN : PH_EXP_NAMLEN;
                r = '{imp ? REC_IMP_CNT : REC_EXP_CNT, v, 1'b0, 1'b0};
                return 1'b1;
            end
            PH_IMP_MODLEN:
            begin
                if (!leb_take(b, v))
                    return 1'b0;
                bytes_left = v;
                phase = (v != 32'd0) ? PH_IMP_MODCHR : PH_IMP_NAMLEN;
                r = '{REC_MOD_LEN, v, 1'b0, 1'b0};
                return 1'b1;
            end
            PH_IMP_MODCHR:
            begin
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0)
                    phase = PH_IMP_NAMLEN;
                r = '{REC_MOD_CHR, 32'(b), 1'b0, 1'b0};
                return 1'b1;
            end
            PH_IMP_NAMLEN, PH_EXP_NAMLEN:
            begin
                imp = (phase == PH_IMP_NAMLEN);
                if (!leb_take(b, v))
                    return 1'b0;
                bytes_left = v;
                if (v != 32'd0)
                    phase = imp ? PH_IMP_NAMCHR : PH_EXP_NAMCHR;
                else
                    phase = imp ? PH_IMP_KIND : PH_EXP_KIND;
                r = '{REC_NAM_LEN, v, 1'b0, 1'b0};
                return 1'b1;
            end
            PH_IMP_NAMCHR, PH_EXP_NAMCHR:
            begin
                imp = (phase == PH_IMP_NAMCHR);
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0)
                    phase = imp ? PH_IMP_KIND : PH_EXP_KIND;
                r = '{REC_NAM_CHR, 32'(b), 1'b0, 1'b0};
                return 1'b1;
            end
            PH_IMP_KIND:
            begin
                if (b > 8'd3)
                begin
                    r = '{REC_IMP_KIND, 32'(b), 1'b1, 1'b0};
                    r.all = close_entry(1'b1);
                    return 1'b1;
                end
                phase = (b == 8'd0) ? PH_IMP_TYPEIDX : (b == 8'd1) ? PH_IMP_ELEM
                      : (b == 8'd2) ? PH_IMP_FLAGS : PH_IMP_VALTYPE;
                r = '{REC_IMP_KIND, 32'(b), 1'b0, 1'b0};
                return 1'b1;
            end
            PH_IMP_TYPEIDX:
            begin
                if (!leb_take(b, v))
                    return 1'b0;
                r = '{REC_TYPE_IDX, v, 1'b1, 1'b0};
                r.all = close_entry(1'b1);
                return 1'b1;
            end
            PH_IMP_ELEM:
            begin
                phase = PH_IMP_FLAGS;
                r = '{REC_ELEM, 32'(b), 1'b0, 1'b0};
                return 1'b1;
            end
            PH_IMP_FLAGS:
            begin
                has_max = b[0];
                phase = PH_IMP_INIT;
                return 1'b0;
            end
            PH_IMP_INIT:
            begin
                if (!leb_take(b, v))
                    return 1'b0;
                if (has_max)
                begin
                    phase = PH_IMP_MAX;
                    r = '{REC_INIT, v, 1'b0, 1'b0};
                    return 1'b1;
                end
                r = '{REC_INIT, v, 1'b1, 1'b0};
                r.all = close_entry(1'b1);
                return 1'b1;
            end
            PH_IMP_MAX:
            begin
                if (!leb_take(b, v))
                    return 1'b0;
                r = '{REC_MAX, v, 1'b1, 1'b0};
                r.all = close_entry(1'b1);
                return 1'b1;
            end
            PH_IMP_VALTYPE:
            begin
                phase = PH_IMP_MUT;
                r = '{REC_VALTYPE, 32'(b), 1'b0, 1'b0};
                return 1'b1;
            end
            PH_IMP_MUT:
            begin
                r = '{REC_MUT, (b != 8'd0) ? 32'd1 : 32'd0, 1'b1, 1'b0};
                r.all = close_entry(1'b1);
                return 1'b1;
            end
            PH_EXP_KIND:
            begin
                phase = PH_EXP_INDEX;
                r = '{REC_EXP_KIND, 32'(b), 1'b0, 1'b0};
                return 1'b1;
            end
            PH_EXP_INDEX:
            begin
                if (!leb_take(b, v))
                    return 1'b0;
                r = '{REC_EXP_IDX, v, 1'b1, 1'b0};
                r.all = close_entry(1'b0);
                return 1'b1;
            end
            default:
            begin
                phase = PH_DONE;
                return 1'b0;
            end
        endcase
    endfunction

    // send one byte; the predictor runs on the accepting edge
    task automatic send_byte(input logic [7:0] b, input logic sof, input logic random_gaps);
        record_t r;
        while (random_gaps && !quiet && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        do
            @(posedge clk);
        while (!s_tready);
        if (decode_byte(b, sof, r))
            expected_records.push_back(r);
        bytes_sent++;
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tuser  <= 1'b0;
    endtask

    // queue builders for the random modules
    task automatic put_leb(input logic [31:0] v, input int extra);
        logic [31:0] x;
        x = v;
        do
        begin
            stream.push_back({(x > 32'd127) || (extra > 0), x[6:0]});
            x = x >> 7;
            stream_sof.push_back(1'b0);
        end
        while (x != 32'd0);
        for (int i = 0; i < extra; i++)
        begin
            stream.push_back({(i < extra - 1), 7'($urandom)});
            stream_sof.push_back(1'b0);
        end
    endtask

    task automatic put_b(input logic [7:0] b);
        stream.push_back(b);
        stream_sof.push_back(1'b0);
    endtask

    task automatic put_str(input int n);
        put_leb(n, 0);
        for (int i = 0; i < n; i++)
            put_b(8'($urandom));
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(3))
            0: return $urandom_range(3);
            1: return $urandom_range(300);
            2: return $urandom;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic build_module();
        int n;
        int kind;
        // header, sometimes damaged
        for (int i = 0; i < 8; i++)
        begin
            put_b(($urandom_range(99) < 6) ? 8'($urandom) : hdr_byte(3'(i)));
            if (i == 0)
                stream_sof[$] = 1'b1;
        end
        for (int s = 0; s < 4; s++)
        begin
            case ($urandom_range(5))
                0, 1:
                begin
                    put_b(8'd2);
                    put_leb($urandom_range(40), $urandom_range(1));
                    n = $urandom_range(4);
                    put_leb(n, ($urandom_range(9) == 0) ? 2 : 0);
                    for (int e = 0; e < n; e++)
                    begin
                        put_str($urandom_range(3));
                        put_str($urandom_range(3));
                        kind = ($urandom_range(9) == 0) ? $urandom_range(4, 255)
                                                          : $urandom_range(3);
                        put_b(8'(kind));
                        case (kind)
                            0: put_leb(rand_val(), $urandom_range(1) * $urandom_range(2));
                            1, 2:
                            begin
                                if (kind == 1)
                                    put_b(8'($urandom));
                                put_b(8'($urandom));
                                if (stream[$][0])
                                begin
                                    put_leb(rand_val(), 0);
                                    put_leb(rand_val(), 0);
                                end
                                else
                                    put_leb(rand_val(), 0);
                            end
                            3:
                            begin
                                put_b(8'($urandom));
                                put_b(($urandom_range(1) != 0) ? 8'($urandom) : 8'd0);
                            end
                            default: ;
                        endcase
                    end
                end
                2, 3:
                begin
                    put_b(8'd7);
                    put_leb($urandom_range(40), 0);
                    n = $urandom_range(4);
                    put_leb(n, 0);
                    for (int e = 0; e < n; e++)
                    begin
                        put_str($urandom_range(3));
                        put_b(8'($urandom));
                        put_leb(rand_val(), $urandom_range(1));
                    end
                end
                default:
                begin
                    n = $urandom_range(6);
                    put_b(8'($urandom));
                    put_leb(n, 0);
                    for (int i = 0; i < n; i++)
                        put_b(8'($urandom));
                end
            endcase
        end
        // trailing noise
        for (int i = $urandom_range(3); i > 0; i--)
            put_b(8'($urandom));
    endtask

    // directed stimulus: expectations typed in where obvious
    stim_row_t directed[] = '{
        '{8'h00, 1'b1, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h61, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h73, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, REC_BAD_HDR, 32'd0, 1'b1, 1'b0},
        '{8'h02, 1'b0, 1'b1, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        // good header, export count zero, import count zero as a two-byte LEB
        '{8'h00, 1'b1, 1'b1, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h61, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h73, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h6D, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h07, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, REC_EXP_CNT, 32'd0, 1'b1, 1'b0},
        '{8'h02, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, REC_IMP_CNT, 32'd0, 1'b1, 1'b1},
        '{8'hFF, 1'b0, 1'b1, 1'b0, REC_BAD_HDR, 32'd0, 1'b0, 1'b0}
    };

    // result checker
    always @(posedge clk)
    begin
        record_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_records.size() == 0)
            begin
                report_mismatch("unexpected record", 32'(m_tdata[3:0]), 32'd0);
            end
            else
            begin
                want = expected_records.pop_front();
                if (m_tdata[3:0] !== want.rtype)
                    report_mismatch("record_type", 32'(m_tdata[3:0]), 32'(want.rtype));
                if (m_tdata[35:4] !== want.value)
                    report_mismatch("record_value", m_tdata[35:4], want.value);
                if (m_tlast !== want.last)
                    report_mismatch("group_last", 32'(m_tlast), 32'(want.last));
                if (m_tuser !== want.all)
                    report_mismatch("all_found", 32'(m_tuser), 32'(want.all));
            end
        end
    end

    // receiver: random stalls, a long hold-off, and a quiet stretch
    always @(posedge clk)
    begin
        if (!rst_n || rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= quiet || ($urandom_range(99) >= 20);
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        record_t r;
        int      drained;
        error_count = 0;
        bytes_sent  = 0;
        rx_hold     = 1'b0;
        quiet       = 1'b0;
        rst_n       = 1'b0;
        m_tready    = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tuser     = 1'b0;
        parser_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; typed expectations are checked against the predictor
        foreach (directed[i])
        begin
            send_byte(directed[i].data, directed[i].sof, 1'b1);
            if (directed[i].chk)
            begin
                if (directed[i].has)
                begin
                    r = expected_records[$];
                    if (r != record_t'{directed[i].rtype, directed[i].value,
                                       directed[i].last, directed[i].all})
                        report_mismatch("directed row", i, 32'(directed[i].rtype));
                end
            end
        end

        // sender pause until every record has drained
        idle_sender();
        wait (expected_records.size() == 0);
        @(posedge clk);

        // long receiver hold-off while a module keeps coming
        fork
            begin
                rx_hold = 1'b1;
                repeat (60) @(posedge clk);
                rx_hold = 1'b0;
            end
        join_none

        while (bytes_sent < 1050)
        begin
            if (stream.size() == 0)
                build_module();
            quiet = (bytes_sent > 500) && (bytes_sent < 650);
            send_byte(stream.pop_front(), stream_sof.pop_front(), 1'b1);
        end
        idle_sender();

        wait (expected_records.size() == 0);
        drained = 0;
        while (drained < 20)
        begin
            @(posedge clk);
            drained++;
        end
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- wasm_import_export_parser.f -----
rtl/wiep_pkg.sv
rtl/wiep_front.sv
rtl/wiep_queue.sv
rtl/wasm_import_export_parser.sv
tb/tb_wasm_import_export_parser.sv
